// File: rtl/core/dwpq_pkg.sv
`timescale 1ns / 1ps

package dwpq_pkg;

    // Sizes of the queue and of the id space. Both are powers of two, so
    // ring wrap and id reduction are plain truncations.
    localparam int QUEUE_DEPTH = 1024;
    localparam int ID_COUNT    = 1024;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int ID_W   = $clog2(ID_COUNT);
    localparam int CNT_W  = SLOT_W + 1;

    // Widths of the item fields.
    localparam int CMD_W = 3;
    localparam int PID_W = 10;
    localparam int VAL_W = 10;
    localparam int STS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

    // Status codes.
    localparam logic [STS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY  = 2'd1;
    localparam logic [STS_W-1:0] STS_ABSENT = 2'd2;
    localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

    // One entry of the id map: present bit and the slot of the last push.
    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } map_entry_t;

    // Access request to the slot store.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SLOT_W-1:0] addr;
        logic [ID_W-1:0]   wdata;
    } slot_req_t;

    // Access request to the id map.
    typedef struct packed {
        logic            rd_en;
        logic            wr_en;
        logic [ID_W-1:0] addr;
        map_entry_t      wdata;
    } map_req_t;

endpackage

// File: rtl/core/dwpq_slot_store.sv
`timescale 1ns / 1ps

// Ring buffer storage: the id held in each slot. Read data is registered.
module dwpq_slot_store (
    input  logic                        aclk,
    input  dwpq_pkg::slot_req_t         req,
    output logic [dwpq_pkg::ID_W-1:0]   rdata
);
    import dwpq_pkg::*;

    logic [ID_W-1:0] mem [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata <= mem[req.addr];
        end
    end

endmodule

// File: rtl/core/dwpq_id_map.sv
`timescale 1ns / 1ps

// Map from id to its present bit and last slot. Read data is registered.
module dwpq_id_map (
    input  logic                 aclk,
    input  dwpq_pkg::map_req_t   req,
    output dwpq_pkg::map_entry_t rdata
);
    import dwpq_pkg::*;

    map_entry_t mem [ID_COUNT];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata <= mem[req.addr];
        end
    end

endmodule

// File: rtl/core/dwpq_ctrl.sv
`timescale 1ns / 1ps

// Command sequencer: clears the id map after reset, then takes one item at a
// time, steps through the memory reads it needs and writes back the result.
module dwpq_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dwpq_pkg::CMD_W-1:0]   s_command,
    input  logic [dwpq_pkg::PID_W-1:0]   s_person_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dwpq_pkg::VAL_W-1:0]   m_result_value,
    output logic [dwpq_pkg::STS_W-1:0]   m_status,
    output dwpq_pkg::slot_req_t          slot_req,
    input  logic [dwpq_pkg::ID_W-1:0]    slot_rdata,
    output dwpq_pkg::map_req_t           map_req,
    input  dwpq_pkg::map_entry_t         map_rdata
);
    import dwpq_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SLOT  = 3'd2;
    localparam logic [2:0] ST_MAP   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ID_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [STS_W-1:0]  res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic [STS_W-1:0]  m_status_reg, m_status_next;

    logic              accept;
    logic [ID_W-1:0]   in_id;
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] back_slot;
    logic              out_load;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign in_id          = s_person_id[ID_W-1:0];
    assign empty          = (count_reg == '0);
    assign full           = count_reg[CNT_W-1];
    assign tail_slot      = head_reg + count_reg[SLOT_W-1:0];
    assign back_slot      = tail_slot - SLOT_W'(1);
    assign out_load       = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        slot_next       = slot_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        slot_req        = '0;
        map_req         = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                map_req.wr_en = 1'b1;
                map_req.addr  = clr_cnt_reg;
                clr_cnt_next  = clr_cnt_reg + ID_W'(1);
                if (clr_cnt_reg == ID_W'(ID_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd_next       = s_command;
                    id_next        = in_id;
                    res_value_next = '0;
                    unique case (s_command)
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                res_status_next = STS_FULL;
                                state_next      = ST_OUT;
                            end else begin
                                slot_req.wr_en = 1'b1;
                                slot_req.addr  = tail_slot;
                                slot_req.wdata = in_id;
                                map_req.wr_en  = 1'b1;
                                map_req.addr   = in_id;
                                map_req.wdata  = '{present: 1'b1, slot: tail_slot};
                                count_next     = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK: begin
                            if (empty) begin
                                res_status_next = STS_EMPTY;
                                state_next      = ST_OUT;
                            end else begin
                                slot_next      = (s_command == CMD_POP_BACK) ?
                                                 back_slot : head_reg;
                                slot_req.rd_en = 1'b1;
                                slot_req.addr  = slot_next;
                                state_next     = ST_SLOT;
                            end
                        end
                        CMD_QUERY: begin
                            map_req.rd_en = 1'b1;
                            map_req.addr  = in_id;
                            state_next    = ST_MAP;
                        end
                        default: begin
                            // Unused codes are dropped without a result.
                        end
                    endcase
                end
            end
            ST_SLOT: begin
                if (cmd_reg == CMD_PEEK) begin
                    res_value_next  = VAL_W'(slot_rdata);
                    res_status_next = STS_OK;
                    state_next      = ST_OUT;
                end else begin
                    // A pop: look up the map entry of the id leaving the queue.
                    id_next       = slot_rdata;
                    map_req.rd_en = 1'b1;
                    map_req.addr  = slot_rdata;
                    state_next    = ST_MAP;
                end
            end
            ST_MAP: begin
                if (cmd_reg == CMD_QUERY) begin
                    if (map_rdata.present) begin
                        res_value_next  = VAL_W'(map_rdata.slot - head_reg);
                        res_status_next = STS_OK;
                    end else begin
                        res_status_next = STS_ABSENT;
                    end
                    state_next = ST_OUT;
                end else begin
                    // Clear the present bit only if this slot is the id's latest.
                    if (map_rdata.present && (map_rdata.slot == slot_reg)) begin
                        map_req.wr_en = 1'b1;
                        map_req.addr  = id_reg;
                        map_req.wdata = '{present: 1'b0, slot: slot_reg};
                    end
                    if (cmd_reg == CMD_POP_FRONT) begin
                        head_next = head_reg + SLOT_W'(1);
                    end
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_value_next  = res_value_reg;
            m_status_next = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        slot_reg       <= slot_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// File: rtl/core/deque_with_position_query_top.sv
`timescale 1ns / 1ps
// A peek or query result passes a registered memory read, the result registers
// and ST_OUT on its way to the output register; an error result skips the read.
// One item at a time: a push leaves the controller idle, an error goes via ST_OUT,
// a pop via ST_SLOT and ST_MAP, a peek via ST_SLOT and ST_OUT, a query via ST_MAP
// and ST_OUT; a waiting result holds it in ST_OUT. Reset (synchronous, aresetn low)
// empties the queue and clears all 1024 id map entries, with s_ready low till done.

// The queue is a ring buffer of ids in the slot store, addressed by a head
// pointer and an entry count. The id map holds, for each id, a present bit and
// the slot of its last push, so a position is that slot minus the head,
// wrapped to the ring depth. Pushes write both memories in the cycle the item
// is taken. A pop first reads the slot to learn the id leaving the queue, then
// reads that id's map entry and clears its present bit only when the map still
// points to the popped slot, so that an older copy of a re-pushed id leaves the
// map alone. Results wait in an output register, so the controller is never
// held by the consumer except when a second result is ready before the first
// has been taken.
module deque_with_position_query_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dwpq_pkg::CMD_W-1:0]   s_command,
    input  logic [dwpq_pkg::PID_W-1:0]   s_person_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dwpq_pkg::VAL_W-1:0]   m_result_value,
    output logic [dwpq_pkg::STS_W-1:0]   m_status
);
    import dwpq_pkg::*;

    slot_req_t       slot_req;
    logic [ID_W-1:0] slot_rdata;
    map_req_t        map_req;
    map_entry_t      map_rdata;

    dwpq_slot_store u_slot_store (
        .aclk  (aclk),
        .req   (slot_req),
        .rdata (slot_rdata)
    );

    dwpq_id_map u_id_map (
        .aclk  (aclk),
        .req   (map_req),
        .rdata (map_rdata)
    );

    dwpq_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_person_id    (s_person_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .slot_req       (slot_req),
        .slot_rdata     (slot_rdata),
        .map_req        (map_req),
        .map_rdata      (map_rdata)
    );

endmodule

// File: rtl/core/dwpq_checker.sv
`timescale 1ns / 1ps

module dwpq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [dwpq_pkg::CMD_W-1:0]   s_command,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [dwpq_pkg::VAL_W-1:0]   m_result_value,
    input logic [dwpq_pkg::STS_W-1:0]   m_status
);
    import dwpq_pkg::*;

    // A stalled result keeps its value and status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
    else $error("result item changed while stalled");

    // The map clearing pass holds off input items right after reset.
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
    else $error("input taken during the clearing pass");

    // Any error status carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STS_OK) |-> (m_result_value == '0))
    else $error("error result with nonzero value");

    // A position query needs a map read, so no item is taken in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_QUERY) |=> !s_ready)
    else $error("item taken while a query is in flight");

endmodule

bind deque_with_position_query_top dwpq_checker u_dwpq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_command      (s_command),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_status       (m_status)
);
